### sv/hsvrgb_pkg.sv
// hsvrgb_pkg: shared types, constants and helpers for the hsv to rgb converter
// no dependencies; imported by the sector, level, mix and top modules
`timescale 1ns / 1ps

package hsvrgb_pkg;

	// field widths
	localparam int HUE_W    = 9;
	localparam int LEVEL_W  = 8;
	localparam int SECTOR_W = 4;
	localparam int POS_W    = 6;
	localparam int PROD_W   = 14;
	localparam int WIDE_W   = 16;

	// hue / 60 by reciprocal: (hue * 1093) >> 16, exact for hue below 512
	localparam logic [10:0] HUE_RECIP      = 11'd1093;
	localparam int          HUE_RECIP_SHR  = 16;
	// n / 60 by reciprocal: (n * 17477) >> 20, exact for n up to 255 * 60
	localparam logic [14:0] SIXTY_RECIP     = 15'd17477;
	localparam int          SIXTY_RECIP_SHR = 20;

	localparam logic [6:0]         SECTOR_DEG = 7'd60;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 8'd255;

	// sector codes, hue / 60
	localparam logic [SECTOR_W-1:0] SEC_RED_YELLOW    = 4'd0;
	localparam logic [SECTOR_W-1:0] SEC_YELLOW_GREEN  = 4'd1;
	localparam logic [SECTOR_W-1:0] SEC_GREEN_CYAN    = 4'd2;
	localparam logic [SECTOR_W-1:0] SEC_CYAN_BLUE     = 4'd3;
	localparam logic [SECTOR_W-1:0] SEC_BLUE_MAGENTA  = 4'd4;
	localparam logic [SECTOR_W-1:0] SEC_MAGENTA_RED   = 4'd5;

	// input pixel
	typedef struct packed {
		logic [HUE_W-1:0]   hue;
		logic [LEVEL_W-1:0] sat;
		logic [LEVEL_W-1:0] val;
		logic [LEVEL_W-1:0] alpha;
	} pix_in_t;

	// after sector split
	typedef struct packed {
		logic                gray;
		logic [SECTOR_W-1:0] sector;
		logic [HUE_W-1:0]    hue;
		logic [LEVEL_W-1:0]  sat;
		logic [LEVEL_W-1:0]  val;
		logic [LEVEL_W-1:0]  alpha;
	} sec_t;

	// saturation products across the sector
	typedef struct packed {
		logic                gray;
		logic [SECTOR_W-1:0] sector;
		logic [LEVEL_W-1:0]  sat;
		logic [LEVEL_W-1:0]  val;
		logic [LEVEL_W-1:0]  alpha;
		logic [PROD_W-1:0]   p_fall;
		logic [PROD_W-1:0]   p_rise;
	} prod_t;

	// scaled saturation terms and the flat level product
	typedef struct packed {
		logic                gray;
		logic [SECTOR_W-1:0] sector;
		logic [LEVEL_W-1:0]  val;
		logic [LEVEL_W-1:0]  alpha;
		logic [LEVEL_W-1:0]  x_fall;
		logic [LEVEL_W-1:0]  x_rise;
		logic [WIDE_W-1:0]   m_flat;
	} scale_t;

	// three level products before the divide by 255
	typedef struct packed {
		logic                gray;
		logic [SECTOR_W-1:0] sector;
		logic [LEVEL_W-1:0]  val;
		logic [LEVEL_W-1:0]  alpha;
		logic [WIDE_W-1:0]   m_flat;
		logic [WIDE_W-1:0]   m_fall;
		logic [WIDE_W-1:0]   m_rise;
	} level_t;

	// output pixel
	typedef struct packed {
		logic [LEVEL_W-1:0] red;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] blue;
		logic [LEVEL_W-1:0] alpha;
	} pix_out_t;

	// n / 255 for n below 65280: (n + (n >> 8) + 1) >> 8
	function automatic logic [LEVEL_W-1:0] div255(input logic [WIDE_W-1:0] n);
		logic [WIDE_W:0] sum;
		sum = {1'b0, n} + {9'd0, n[WIDE_W-1:8]} + 17'd1;
		return sum[WIDE_W-1:8];
	endfunction

endpackage

### sv/hsvrgb_sector.sv
// hsvrgb_sector: stages 1 and 2, sector split and saturation products
// depends on hsvrgb_pkg
`timescale 1ns / 1ps

module hsvrgb_sector import hsvrgb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  pix_in_t in_beat,
	output logic    out_valid,
	input  logic    out_ready,
	output prod_t   out_beat
);

	logic  v_s1, v_s2;
	sec_t  d_s1;
	prod_t d_s2;
	logic  en_s1, en_s2;

	// a stage loads when empty or when its contents move on
	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// stage 1: sector = hue / 60
	logic [19:0] hue_mul;
	sec_t        nxt_s1;
	always_comb begin
		hue_mul       = {11'd0, in_beat.hue} * {9'd0, HUE_RECIP};
		nxt_s1.gray   = (in_beat.sat == '0);
		nxt_s1.sector = hue_mul[HUE_RECIP_SHR +: SECTOR_W];
		nxt_s1.hue    = in_beat.hue;
		nxt_s1.sat    = in_beat.sat;
		nxt_s1.val    = in_beat.val;
		nxt_s1.alpha  = in_beat.alpha;
	end

	// stage 2: position in sector and the two saturation products
	logic [9:0]       base;
	logic [9:0]       diff;
	logic [POS_W-1:0] pos;
	logic [6:0]       pos_rest;
	prod_t            nxt_s2;
	always_comb begin
		base            = ({6'd0, d_s1.sector} << 6) - ({6'd0, d_s1.sector} << 2);
		diff            = {1'b0, d_s1.hue} - base;
		pos             = diff[POS_W-1:0];
		pos_rest        = SECTOR_DEG - {1'b0, pos};
		nxt_s2.gray     = d_s1.gray;
		nxt_s2.sector   = d_s1.sector;
		nxt_s2.sat      = d_s1.sat;
		nxt_s2.val      = d_s1.val;
		nxt_s2.alpha    = d_s1.alpha;
		nxt_s2.p_fall   = {6'd0, d_s1.sat} * {8'd0, pos};
		nxt_s2.p_rise   = {6'd0, d_s1.sat} * {7'd0, pos_rest};
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en_s1) d_s1 <= nxt_s1;
		if (en_s2) d_s2 <= nxt_s2;
	end

	assign out_valid = v_s2;
	assign out_beat  = d_s2;

endmodule

### sv/hsvrgb_level.sv
// hsvrgb_level: stages 3 and 4, divide by 60 and the brightness products
// depends on hsvrgb_pkg
`timescale 1ns / 1ps

module hsvrgb_level import hsvrgb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  prod_t  in_beat,
	output logic   out_valid,
	input  logic   out_ready,
	output level_t out_beat
);

	logic   v_s3, v_s4;
	scale_t d_s3;
	level_t d_s4;
	logic   en_s3, en_s4;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign in_ready = en_s3;

	// stage 3: products / 60, flat level product
	logic [28:0] fall_mul, rise_mul;
	scale_t      nxt_s3;
	always_comb begin
		fall_mul        = {15'd0, in_beat.p_fall} * {14'd0, SIXTY_RECIP};
		rise_mul        = {15'd0, in_beat.p_rise} * {14'd0, SIXTY_RECIP};
		nxt_s3.gray     = in_beat.gray;
		nxt_s3.sector   = in_beat.sector;
		nxt_s3.val      = in_beat.val;
		nxt_s3.alpha    = in_beat.alpha;
		nxt_s3.x_fall   = fall_mul[SIXTY_RECIP_SHR +: LEVEL_W];
		nxt_s3.x_rise   = rise_mul[SIXTY_RECIP_SHR +: LEVEL_W];
		nxt_s3.m_flat   = {8'd0, in_beat.val} * {8'd0, LEVEL_MAX - in_beat.sat};
	end

	// stage 4: brightness times the falling and rising terms
	level_t nxt_s4;
	always_comb begin
		nxt_s4.gray   = d_s3.gray;
		nxt_s4.sector = d_s3.sector;
		nxt_s4.val    = d_s3.val;
		nxt_s4.alpha  = d_s3.alpha;
		nxt_s4.m_flat = d_s3.m_flat;
		nxt_s4.m_fall = {8'd0, d_s3.val} * {8'd0, LEVEL_MAX - d_s3.x_fall};
		nxt_s4.m_rise = {8'd0, d_s3.val} * {8'd0, LEVEL_MAX - d_s3.x_rise};
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s3) v_s3 <= in_valid;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en_s3) d_s3 <= nxt_s3;
		if (en_s4) d_s4 <= nxt_s4;
	end

	assign out_valid = v_s4;
	assign out_beat  = d_s4;

endmodule

### sv/hsvrgb_mix.sv
// hsvrgb_mix: stage 5, divide by 255 and channel order per sector, output register
// depends on hsvrgb_pkg
`timescale 1ns / 1ps

module hsvrgb_mix import hsvrgb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  level_t   in_beat,
	output logic     out_valid,
	input  logic     out_ready,
	output pix_out_t out_beat
);

	logic     v_s5;
	pix_out_t d_s5;
	logic     en_s5;

	assign en_s5    = !v_s5 || out_ready;
	assign in_ready = en_s5;

	// levels and channel routing
	logic [LEVEL_W-1:0] c_flat, c_fall, c_rise;
	pix_out_t           nxt_s5;
	always_comb begin
		c_flat       = div255(in_beat.m_flat);
		c_fall       = div255(in_beat.m_fall);
		c_rise       = div255(in_beat.m_rise);
		nxt_s5.alpha = in_beat.alpha;
		if (in_beat.gray) begin
			nxt_s5.red   = in_beat.val;
			nxt_s5.green = in_beat.val;
			nxt_s5.blue  = in_beat.val;
		end else begin
			unique case (in_beat.sector)
				SEC_RED_YELLOW: begin
					nxt_s5.red   = in_beat.val;
					nxt_s5.green = c_rise;
					nxt_s5.blue  = c_flat;
				end
				SEC_YELLOW_GREEN: begin
					nxt_s5.red   = c_fall;
					nxt_s5.green = in_beat.val;
					nxt_s5.blue  = c_flat;
				end
				SEC_GREEN_CYAN: begin
					nxt_s5.red   = c_flat;
					nxt_s5.green = in_beat.val;
					nxt_s5.blue  = c_rise;
				end
				SEC_CYAN_BLUE: begin
					nxt_s5.red   = c_flat;
					nxt_s5.green = c_fall;
					nxt_s5.blue  = in_beat.val;
				end
				SEC_BLUE_MAGENTA: begin
					nxt_s5.red   = c_rise;
					nxt_s5.green = c_flat;
					nxt_s5.blue  = in_beat.val;
				end
				SEC_MAGENTA_RED: begin
					nxt_s5.red   = in_beat.val;
					nxt_s5.green = c_flat;
					nxt_s5.blue  = c_fall;
				end
				// hue of 360 and above
				default: begin
					nxt_s5.red   = '0;
					nxt_s5.green = '0;
					nxt_s5.blue  = '0;
				end
			endcase
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en_s5) begin
			v_s5 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en_s5) d_s5 <= nxt_s5;
	end

	assign out_valid = v_s5;
	assign out_beat  = d_s5;

endmodule

### sv/hsv_to_rgb_integer_core.sv
// hsv_to_rgb_integer_core: top level of the hsv to 8-bit rgb converter
// depends on hsvrgb_pkg, hsvrgb_sector, hsvrgb_level, hsvrgb_mix
//
// usage:
//   one hsv pixel per beat enters on s_axis, one rgb pixel with the same
//   alpha leaves on m_axis, in order, one result for every input beat.
//   zero saturation gives gray at the brightness level; a hue of 360 or
//   more with nonzero saturation gives black.
// path: an accepted input beat is registered in stages 1 to 5 in order and
//   leaves on m_axis as the matching output beat.
// throughput: one pixel per clock while m_axis_tready is high, set by the
//   five-stage pipeline with at most one multiplier per path per stage
//   (sector split, saturation product, divide by 60, brightness product,
//   divide by 255 and channel select).
// reset: arst_n clears all valid bits at once; the pipe is empty and
//   s_axis_tready is high as soon as reset is released.
// stall: when m_axis_tready is low the output beat holds; earlier stages
//   keep filling empty slots and s_axis_tready drops once all five stages
//   are full. nothing is dropped or repeated.
`timescale 1ns / 1ps

module hsv_to_rgb_integer_core import hsvrgb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// hue[8:0], saturation[16:9], brightness[24:17], alpha_in[32:25], zero pad
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// red[7:0], green[15:8], blue[23:16], alpha_out[31:24]
	output logic [31:0] m_axis_tdata
);

	pix_in_t  pix_in;
	prod_t    prod_beat;
	level_t   level_beat;
	pix_out_t pix_out;
	logic     prod_valid, prod_ready;
	logic     level_valid, level_ready;

	// unpack the input beat
	assign pix_in.hue   = s_axis_tdata[8:0];
	assign pix_in.sat   = s_axis_tdata[16:9];
	assign pix_in.val   = s_axis_tdata[24:17];
	assign pix_in.alpha = s_axis_tdata[32:25];

	hsvrgb_sector u_sector (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_beat   (pix_in),
		.out_valid (prod_valid),
		.out_ready (prod_ready),
		.out_beat  (prod_beat)
	);

	hsvrgb_level u_level (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prod_valid),
		.in_ready  (prod_ready),
		.in_beat   (prod_beat),
		.out_valid (level_valid),
		.out_ready (level_ready),
		.out_beat  (level_beat)
	);

	hsvrgb_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (level_valid),
		.in_ready  (level_ready),
		.in_beat   (level_beat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_beat  (pix_out)
	);

	// pack the output beat
	assign m_axis_tdata = {pix_out.alpha, pix_out.blue, pix_out.green, pix_out.red};

endmodule

### sv/hsvrgb_checker.sv
// hsvrgb_checker: port-level assertions for hsv_to_rgb_integer_core
// depends on hsv_to_rgb_integer_core (attached by bind)
`timescale 1ns / 1ps

module hsvrgb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [39:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

	// a waiting input beat holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
		else $error("input beat changed while waiting");

	// reset empties the pipe
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("output valid during reset");

	// a draining output frees every stage
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output drains");

	// an empty output stage cannot back up the input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

endmodule

bind hsv_to_rgb_integer_core hsvrgb_checker u_hsvrgb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
